[sv/rcb_pkg.sv]
// Shared types, codes and constant tables for the rectangle-centre bearing core.
// Holds the CORDIC arctangent table and the whole-degree thresholds, both built at elaboration.
// Depends on nothing; every other file of the block imports it.
package rcb_pkg;

  // Fixed-point format of the angle and vector datapath.
  localparam int WORD_W     = 64;
  localparam int Q_FRAC     = 60;
  localparam int MAX_STAGES = 32;
  localparam logic [WORD_W-1:0] Q_ONE = 64'd1 << Q_FRAC;

  // Whole-degree search and result formatting.
  localparam int K_BITS = 7;
  localparam int BRG_W  = 9;
  localparam int OUT_W  = 16;
  localparam logic [K_BITS-1:0] DEG_MAX = 7'd89;

  // Bearings of the directions that are decided by comparison alone.
  localparam logic [BRG_W-1:0] DEG_NORTH = 9'd0;
  localparam logic [BRG_W-1:0] DEG_NE    = 9'd45;
  localparam logic [BRG_W-1:0] DEG_EAST  = 9'd90;
  localparam logic [BRG_W-1:0] DEG_SE    = 9'd135;
  localparam logic [BRG_W-1:0] DEG_SOUTH = 9'd180;
  localparam logic [BRG_W-1:0] DEG_SW    = 9'd225;
  localparam logic [BRG_W-1:0] DEG_WEST  = 9'd270;
  localparam logic [BRG_W-1:0] DEG_NW    = 9'd315;

  // Offsets that fold the first-quadrant angle into the other quadrants.
  localparam logic [BRG_W-1:0] FOLD_Q2   = 9'd179;
  localparam logic [BRG_W-1:0] FOLD_Q3   = 9'd180;
  localparam logic [BRG_W-1:0] FOLD_Q4   = 9'd359;
  localparam logic [BRG_W-1:0] FULL_TURN = 9'd360;

  typedef logic signed [WORD_W-1:0] angle_t;
  typedef angle_t atan_tab_t [MAX_STAGES];
  typedef angle_t deg_tab_t [2**K_BITS];

  // Vector and angle accumulator of one CORDIC stage.
  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } cordic_t;

  // Quadrant and exact-direction result that travel beside the CORDIC data.
  typedef struct packed {
    logic             special;
    logic [BRG_W-1:0] spec_res;
    logic             dx_neg;
    logic             dy_neg;
  } side_t;

  // Restoring long division, used only while the constant tables are built.
  function automatic logic [WORD_W-1:0] udiv64(input logic [WORD_W-1:0] num,
                                               input logic [WORD_W-1:0] den);
    logic [WORD_W:0]   rem;
    logic [WORD_W-1:0] quo;
    rem = '0;
    quo = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      rem = {rem[WORD_W-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/m) in Q60 by the alternating series, each term truncated.
  function automatic angle_t atan_inv(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] sq;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] t;
    angle_t            acc;
    logic              neg;
    logic              done;
    sq   = m * m;
    p    = m;
    n    = 64'd1;
    acc  = '0;
    neg  = 1'b0;
    done = 1'b0;
    for (int j = 0; j < WORD_W; j++) begin
      if (!done) begin
        t   = udiv64(udiv64(Q_ONE, p), n);
        acc = neg ? acc - angle_t'(t) : acc + angle_t'(t);
        if (p > udiv64(Q_ONE, sq)) begin
          done = 1'b1;
        end else begin
          p   = p * sq;
          n   = n + 64'd2;
          neg = !neg;
        end
      end
    end
    return acc;
  endfunction

  // Entry i is atan(2^-i); atan(1) is formed as atan(1/2) + atan(1/3).
  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = atan_inv(64'd2) + atan_inv(64'd3);
    for (int i = 1; i < MAX_STAGES; i++) begin
      tab[i] = atan_inv(64'd1 << i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();
  localparam angle_t    ONE_DEG  = (4 * ATAN_TAB[0]) / 180;

  // Entry k is k whole degrees in Q60.
  function automatic deg_tab_t build_deg_tab();
    deg_tab_t tab;
    for (int k = 0; k < 2**K_BITS; k++) begin
      tab[k] = angle_t'(k) * ONE_DEG;
    end
    return tab;
  endfunction

  localparam deg_tab_t DEG_TAB = build_deg_tab();

endpackage

[sv/rect_centre_bearing_degrees_core.sv]
// Top level of the rectangle-centre bearing core: centres, differences, CORDIC and degree search.
// Depends on rcb_pkg and rcb_cordic_stage.
//
//   channel | direction | tdata fields, lowest bits first                     | tuser
//   s_axis  | in        | first_left, first_top, first_width, first_height,  | none
//           |           | second_left, second_top, second_width, second_height |
//   m_axis  | out       | bearing_deg, zero padded to 16 bits                 | none
//
// One request is taken per cycle while the skid entry is free; each gives one result.
// Each request passes three input stages, the chain of vectoring stages, seven binary
// search stages for the whole degree and the output register.
// Reset clears the valid bits only; no clearing pass is needed.
// A two-entry output (register plus skid) lets input flow on while a result waits; the
// pipeline freezes only when both entries are full, and nothing is dropped or repeated.
module rect_centre_bearing_degrees_core #(
  parameter int COORD_BITS    = 12,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_left, first_top, first_width, first_height,
  // second_left, second_top, second_width, second_height
  input  logic [8*COORD_BITS-1:0]       s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // bearing_deg, then zero padding
  output logic [rcb_pkg::OUT_W-1:0]     m_axis_tdata
);
  import rcb_pkg::*;

  localparam int CW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;
  localparam int SH = Q_FRAC - COORD_BITS;

  logic pipe_en;

  // Input field split.
  logic [COORD_BITS-1:0] fld [8];
  for (genvar f = 0; f < 8; f++) begin : g_fld
    assign fld[f] = s_axis_tdata[f*COORD_BITS +: COORD_BITS];
  end

  // Stage 0: rectangle centres, corner plus half the size rounded down.
  logic [CW-1:0] cen_d [4];
  logic [CW-1:0] cen_q [4];
  logic          v0_q;

  assign cen_d[0] = CW'(fld[0]) + CW'(fld[2] >> 1);
  assign cen_d[1] = CW'(fld[1]) + CW'(fld[3] >> 1);
  assign cen_d[2] = CW'(fld[4]) + CW'(fld[6] >> 1);
  assign cen_d[3] = CW'(fld[5]) + CW'(fld[7] >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cen_q <= cen_d;
    end
  end

  // Stage 1: signed centre differences.
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic                 v1_q;

  assign dx_d = $signed({1'b0, cen_q[2]}) - $signed({1'b0, cen_q[0]});
  assign dy_d = $signed({1'b0, cen_q[3]}) - $signed({1'b0, cen_q[1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Stage 2: magnitudes, exact directions and the CORDIC start vector.
  logic [DW-1:0] adx, ady;
  logic [CW-1:0] mx, my;
  logic          dx_neg, dy_neg;
  side_t         side_d, side_q;
  cordic_t       init_d, init_q;
  logic          v2_q;

  assign dx_neg = dx_q[DW-1];
  assign dy_neg = dy_q[DW-1];
  assign adx    = dx_neg ? (~dx_q + 1'b1) : dx_q;
  assign ady    = dy_neg ? (~dy_q + 1'b1) : dy_q;
  assign mx     = adx[CW-1:0];
  assign my     = ady[CW-1:0];

  always_comb begin
    side_d.dx_neg  = dx_neg;
    side_d.dy_neg  = dy_neg;
    side_d.special = 1'b1;
    if (dx_q == '0) begin
      side_d.spec_res = dy_neg ? DEG_SOUTH : DEG_NORTH;
    end else if (dy_q == '0) begin
      side_d.spec_res = dx_neg ? DEG_WEST : DEG_EAST;
    end else if (mx == my) begin
      if (!dx_neg) begin
        side_d.spec_res = dy_neg ? DEG_SE : DEG_NE;
      end else begin
        side_d.spec_res = dy_neg ? DEG_SW : DEG_NW;
      end
    end else begin
      side_d.special  = 1'b0;
      side_d.spec_res = DEG_NORTH;
    end
  end

  assign init_d.x = $signed(WORD_W'(my) << SH);
  assign init_d.y = $signed(WORD_W'(mx) << SH);
  assign init_d.z = '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      side_q <= side_d;
      init_q <= init_d;
    end
  end

  // CORDIC vectoring chain, one stage per table entry for the first CORDIC_STAGES entries.
  cordic_t cd [CORDIC_STAGES+1];
  side_t   cs [CORDIC_STAGES+1];
  logic    cv [CORDIC_STAGES+1];

  assign cd[0] = init_q;
  assign cs[0] = side_q;
  assign cv[0] = v2_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rcb_cordic_stage #(
      .SHIFT (g),
      .ANGLE (ATAN_TAB[g])
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (cv[g]),
      .data_i  (cd[g]),
      .side_i  (cs[g]),
      .valid_o (cv[g+1]),
      .data_o  (cd[g+1]),
      .side_o  (cs[g+1])
    );
  end

  // Whole-degree binary search: the largest k up to 89 with k degrees not above z.
  angle_t            sz [K_BITS+1];
  logic [K_BITS-1:0] sk [K_BITS+1];
  side_t             ss [K_BITS+1];
  logic              sv [K_BITS+1];

  assign sz[0] = cd[CORDIC_STAGES].z;
  assign sk[0] = '0;
  assign ss[0] = cs[CORDIC_STAGES];
  assign sv[0] = cv[CORDIC_STAGES];

  for (genvar g = 0; g < K_BITS; g++) begin : g_search
    localparam int BIT = K_BITS - 1 - g;
    logic [K_BITS-1:0] cand;
    logic              take;
    angle_t            z_q;
    logic [K_BITS-1:0] k_q;
    side_t             s_q;
    logic              v_q;

    assign cand = sk[g] | (K_BITS'(1) << BIT);
    assign take = (cand <= DEG_MAX) && (DEG_TAB[cand] <= sz[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (pipe_en) begin
        v_q <= sv[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        z_q <= sz[g];
        k_q <= take ? cand : sk[g];
        s_q <= ss[g];
      end
    end

    assign sz[g+1] = z_q;
    assign sk[g+1] = k_q;
    assign ss[g+1] = s_q;
    assign sv[g+1] = v_q;
  end

  // Quadrant fold of the first-quadrant degree count.
  logic [BRG_W-1:0] fdeg, res_d;
  side_t            fside;
  logic             last_v;

  assign fdeg   = BRG_W'(sk[K_BITS]);
  assign fside  = ss[K_BITS];
  assign last_v = sv[K_BITS];

  always_comb begin
    if (fside.special) begin
      res_d = fside.spec_res;
    end else begin
      case ({fside.dx_neg, fside.dy_neg})
        2'b00:   res_d = fdeg;
        2'b01:   res_d = FOLD_Q2 - fdeg;
        2'b11:   res_d = FOLD_Q3 + fdeg;
        default: res_d = FOLD_Q4 - fdeg;
      endcase
    end
  end

  // Output register with a skid entry; the pipeline moves while the skid entry is free.
  logic             out_v_q, skid_v_q;
  logic [BRG_W-1:0] out_q, skid_q;
  logic             out_take, push;

  assign pipe_en  = !skid_v_q;
  assign out_take = out_v_q && m_axis_tready;
  assign push     = pipe_en && last_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (!out_v_q) begin
      out_v_q <= push;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take && skid_v_q) begin
      out_q <= skid_q;
    end else if ((out_take || !out_v_q) && push) begin
      out_q <= res_d;
    end
    if (out_v_q && !out_take && push) begin
      skid_q <= res_d;
    end
  end

  assign s_axis_tready = pipe_en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while the output register is empty");

  // Every delivered bearing lies inside one turn.
  a_bearing_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[BRG_W-1:0] < FULL_TURN))
    else $error("bearing outside 0 to 359 degrees");

  // A frozen pipeline keeps its last stage unchanged.
  a_freeze_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(sv[K_BITS]) && $stable(sk[K_BITS])))
    else $error("pipeline moved while the output side was full");

endmodule

[sv/rcb_cordic_stage.sv]
// One vectoring stage of the CORDIC pipeline: rotate toward the x axis by atan(2^-SHIFT).
// Carries the side information of the request unchanged; depends on rcb_pkg.
module rcb_cordic_stage #(
  parameter int SHIFT = 0,
  parameter logic signed [63:0] ANGLE = 64'sd0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rcb_pkg::cordic_t data_i,
  input  rcb_pkg::side_t   side_i,
  output logic             valid_o,
  output rcb_pkg::cordic_t data_o,
  output rcb_pkg::side_t   side_o
);
  import rcb_pkg::*;

  logic    valid_q;
  cordic_t data_d, data_q;
  side_t   side_q;
  logic signed [WORD_W-1:0] xs, ys;

  // Shifted terms and the rotation direction set by the sign of y.
  assign xs = data_i.x >>> SHIFT;
  assign ys = data_i.y >>> SHIFT;

  always_comb begin
    if (data_i.y > 0) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ANGLE;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ANGLE;
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload moves with the valid bit and holds during a stall.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign side_o  = side_q;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for rect_centre_bearing_degrees_core: drives rectangle pairs on the
// input stream and checks every bearing against an in-bench CORDIC predictor.
// Depends on the core, its stage module and rcb_pkg (for the output width only).
`timescale 1ns / 100ps

module tb_top;

  localparam int COORD_W   = 12;
  localparam int CORDIC_N  = 24;
  localparam int CENTRE_MX = 4095 + 2047;
  localparam int TAB_LEN   = 32;
  localparam int MAX_SHOWN = 10;

  // One request: two rectangles, each a corner and a size.
  typedef struct {
    logic [COORD_W-1:0] first_left;
    logic [COORD_W-1:0] first_top;
    logic [COORD_W-1:0] first_width;
    logic [COORD_W-1:0] first_height;
    logic [COORD_W-1:0] second_left;
    logic [COORD_W-1:0] second_top;
    logic [COORD_W-1:0] second_width;
    logic [COORD_W-1:0] second_height;
  } rect_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                        s_valid = 1'b0;
  logic                        s_axis_tready;
  // first_left, first_top, first_width, first_height,
  // second_left, second_top, second_width, second_height
  logic [8*COORD_W-1:0]        s_data  = '0;
  logic                        m_axis_tvalid;
  logic                        m_ready = 1'b0;
  // bearing_deg, then zero padding
  logic [rcb_pkg::OUT_W-1:0]   m_axis_tdata;

  // Arctangent table and one degree, Q60 radians.
  longint atan_q60 [TAB_LEN];
  longint deg_q60;

  logic [8:0] pending_bearings [$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_cnt   = 0;
  int n_sent     = 0;
  int n_directed = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_in_stall = 0;

  rect_centre_bearing_degrees_core #(
    .COORD_BITS   (COORD_W),
    .CORDIC_STAGES(CORDIC_N)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // atan(1/m) in Q60 from the alternating series, every term truncated.
  function automatic longint atan_recip(input longint unsigned m);
    longint unsigned one_q, sq, p, n, t;
    longint          acc;
    bit              neg, done;
    one_q = 64'd1 << 60;
    sq    = m * m;
    p     = m;
    n     = 1;
    acc   = 0;
    neg   = 1'b0;
    done  = 1'b0;
    while (!done) begin
      t   = one_q / p / n;
      acc = neg ? acc - longint'(t) : acc + longint'(t);
      if (p > one_q / sq) begin
        done = 1'b1;
      end else begin
        p   = p * sq;
        n   = n + 2;
        neg = !neg;
      end
    end
    return acc;
  endfunction

  // Vectoring CORDIC on (|dy|, |dx|), then the largest whole degree up to 89 not above the angle.
  function automatic int first_quadrant_deg(input longint unsigned num,
                                            input longint unsigned den);
    longint x, y, z, xs, ys;
    int     k;
    x = longint'(den << (60 - COORD_W));
    y = longint'(num << (60 - COORD_W));
    z = 0;
    k = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q60[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q60[i];
      end
    end
    while (k < 89 && longint'(k + 1) * deg_q60 <= z) k++;
    return k;
  endfunction

  // Expected bearing of the second centre seen from the first.
  function automatic logic [8:0] bearing_of(input rect_pair_t p);
    longint dx, dy, mx, my;
    int     f, res;
    dx = longint'(p.second_left) + longint'(p.second_width >> 1)
       - longint'(p.first_left) - longint'(p.first_width >> 1);
    dy = longint'(p.second_top) + longint'(p.second_height >> 1)
       - longint'(p.first_top) - longint'(p.first_height >> 1);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    if (dx == 0) begin
      res = (dy < 0) ? 180 : 0;
    end else if (dy == 0) begin
      res = (dx > 0) ? 90 : 270;
    end else if (mx == my) begin
      if (dx > 0) res = (dy > 0) ? 45 : 135;
      else        res = (dy < 0) ? 225 : 315;
    end else begin
      f = first_quadrant_deg(mx, my);
      if (dx > 0) res = (dy > 0) ? f : 179 - f;
      else        res = (dy < 0) ? 180 + f : 359 - f;
    end
    return res[8:0];
  endfunction

  // Splits a centre coordinate into a random corner and size that give it.
  task automatic split_centre(input int c, output logic [COORD_W-1:0] corner,
                              output logic [COORD_W-1:0] size);
    int lo, hi, h;
    lo     = (c > 4095) ? c - 4095 : 0;
    hi     = (c < 2047) ? c : 2047;
    h      = int'($urandom_range(hi, lo));
    size   = COORD_W'(2 * h + int'($urandom_range(1)));
    corner = COORD_W'(c - h);
  endtask

  // Random rectangles whose centres differ by (dx, dy); the offsets are clipped to range.
  task automatic pair_with_offset(input int dx, input int dy, output rect_pair_t p);
    int cx, cy;
    if (dx >  CENTRE_MX) dx =  CENTRE_MX;
    if (dx < -CENTRE_MX) dx = -CENTRE_MX;
    if (dy >  CENTRE_MX) dy =  CENTRE_MX;
    if (dy < -CENTRE_MX) dy = -CENTRE_MX;
    cx = int'($urandom_range((dx > 0) ? CENTRE_MX - dx : CENTRE_MX, (dx < 0) ? -dx : 0));
    cy = int'($urandom_range((dy > 0) ? CENTRE_MX - dy : CENTRE_MX, (dy < 0) ? -dy : 0));
    split_centre(cx,      p.first_left,  p.first_width);
    split_centre(cy,      p.first_top,   p.first_height);
    split_centre(cx + dx, p.second_left, p.second_width);
    split_centre(cy + dy, p.second_top,  p.second_height);
  endtask

  function automatic rect_pair_t raw_pair(input int fl, input int ft, input int fw, input int fh,
                                          input int sl, input int st, input int sw, input int sh);
    rect_pair_t p;
    p.first_left   = COORD_W'(fl);
    p.first_top    = COORD_W'(ft);
    p.first_width  = COORD_W'(fw);
    p.first_height = COORD_W'(fh);
    p.second_left  = COORD_W'(sl);
    p.second_top   = COORD_W'(st);
    p.second_width = COORD_W'(sw);
    p.second_height = COORD_W'(sh);
    return p;
  endfunction

  // Mix of request shapes: uniform fields, near and far offsets, exact directions.
  task automatic random_pair(output rect_pair_t p);
    int sel, m;
    sel = int'($urandom_range(99));
    if (sel < 35) begin
      p = raw_pair($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 55) begin
      pair_with_offset(int'($urandom_range(30)) - 15, int'($urandom_range(30)) - 15, p);
    end else if (sel < 80) begin
      pair_with_offset(int'($urandom_range(2 * CENTRE_MX)) - CENTRE_MX,
                       int'($urandom_range(2 * CENTRE_MX)) - CENTRE_MX, p);
    end else if (sel < 90) begin
      m = int'($urandom_range(CENTRE_MX));
      pair_with_offset($urandom_range(1) ? m : -m, $urandom_range(1) ? m : -m, p);
    end else begin
      m = int'($urandom_range(2 * CENTRE_MX)) - CENTRE_MX;
      if ($urandom_range(1)) pair_with_offset(0, m, p);
      else                   pair_with_offset(m, 0, p);
    end
  endtask

  // Offers one request after a random gap and records its bearing once it is taken.
  task automatic send_pair(input rect_pair_t p);
    while (int'($urandom_range(99)) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {p.second_height, p.second_width, p.second_top, p.second_left,
                p.first_height, p.first_width, p.first_top, p.first_left};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_bearings.push_back(bearing_of(p));
    n_sent++;
  endtask

  task automatic send_random(input int count);
    rect_pair_t p;
    repeat (count) begin
      random_pair(p);
      send_pair(p);
    end
  endtask

  // Holds the input idle until every outstanding result has come back.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bearings.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      m_ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      m_ready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && s_valid && !s_axis_tready) n_in_stall++;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_bearings.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("%0t: unexpected result, bearing_deg %0d", $realtime, m_axis_tdata[8:0]);
      end else begin
        logic [8:0] want;
        want = pending_bearings.pop_front();
        n_checked++;
        if (m_axis_tdata[8:0] !== want || m_axis_tdata[rcb_pkg::OUT_W-1:9] !== '0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("%0t: bearing_deg expected %0d, got %0d (padding %h)", $realtime,
                     want, m_axis_tdata[8:0], m_axis_tdata[rcb_pkg::OUT_W-1:9]);
        end
      end
    end
  end

  // Axes, diagonals, each quadrant, the largest offsets and the rounding of odd sizes.
  task automatic test_exact_directions();
    rect_pair_t p;
    int offs [16][2] = '{'{0, 100}, '{0, -100}, '{100, 0}, '{-100, 0},
                         '{7, 7}, '{7, -7}, '{-7, -7}, '{-7, 7},
                         '{3, 5}, '{3, -5}, '{-3, -5}, '{-3, 5},
                         '{CENTRE_MX, 1}, '{1, CENTRE_MX}, '{-CENTRE_MX, -1}, '{-1, CENTRE_MX}};
    idle_pct  = 0;
    stall_pct = 0;
    send_pair(raw_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(raw_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
    send_pair(raw_pair(0, 0, 0, 0, 4095, 4095, 4095, 4095));
    send_pair(raw_pair(4095, 4095, 4095, 4095, 0, 0, 0, 0));
    send_pair(raw_pair(0, 0, 4095, 4095, 4095, 4095, 0, 0));
    send_pair(raw_pair(10, 10, 1, 1, 10, 10, 0, 0));
    send_pair(raw_pair(10, 10, 3, 3, 11, 11, 0, 0));
    foreach (offs[i]) begin
      pair_with_offset(offs[i][0], offs[i][1], p);
      send_pair(p);
    end
    n_directed = n_sent;
    drain_results();
  endtask

  task automatic test_streaming_full_rate();
    idle_pct  = 0;
    stall_pct = 0;
    send_random(450);
  endtask

  task automatic test_sender_gaps();
    idle_pct  = 62;
    stall_pct = 0;
    send_random(350);
  endtask

  task automatic test_receiver_stalls();
    idle_pct  = 0;
    stall_pct = 62;
    send_random(350);
  endtask

  task automatic test_mixed_gaps();
    idle_pct  = 23;
    stall_pct = 23;
    send_random(350);
  endtask

  // Long output hold while requests keep coming, so the core must stall its input.
  task automatic test_output_hold();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 4 * CORDIC_N + 200;
    send_random(150);
  endtask

  // Requests stop until the pipeline is empty, then resume.
  task automatic test_drain_pause();
    idle_pct  = 0;
    stall_pct = 30;
    send_random(150);
    drain_results();
    send_random(150);
  endtask

  initial begin
    atan_q60[0] = atan_recip(2) + atan_recip(3);
    for (int i = 1; i < TAB_LEN; i++) atan_q60[i] = atan_recip(64'd1 << i);
    deg_q60 = (4 * atan_q60[0]) / 180;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_exact_directions();
    test_streaming_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_output_hold();
    test_drain_pause();

    drain_results();
    repeat (CORDIC_N + 40) @(posedge clk_i);

    $display("Sent %0d rectangle pairs (%0d directed) and checked %0d bearings,",
             n_sent, n_directed, n_checked);
    $display("under four idle/stall mixes, a long output hold (%0d input stall cycles).",
             n_in_stall);
    if (n_errors == 0 && pending_bearings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(2_000_000);
    $display("Timeout with %0d results outstanding", pending_bearings.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
